>>> rtl/core/qvr_pkg.sv
package qvr_pkg;

    localparam int QW    = 16;
    localparam int VW    = 32;
    localparam int PW    = 2 * QW;
    localparam int NW    = PW + 1;
    localparam int CW    = PW + 2;
    localparam int MW    = CW + VW;
    localparam int SW    = MW + 2;
    localparam int RW    = NW;
    localparam int QBITS = VW;
    localparam int DIV_STAGES = QBITS;
    localparam int IN_W  = 4 * QW + 3 * VW;
    localparam int OUT_W = 3 * VW;

    typedef logic signed [CW-1:0] coef_t;

    typedef struct packed {
        logic [VW-1:0] vz;
        logic [VW-1:0] vy;
        logic [VW-1:0] vx;
        logic [QW-1:0] w;
        logic [QW-1:0] z;
        logic [QW-1:0] y;
        logic [QW-1:0] x;
    } in_item_t;

    typedef struct packed {
        coef_t [8:0]         c;
        logic [NW-1:0]       n;
        logic [2:0][VW-1:0]  v;
    } coef_item_t;

    typedef struct packed {
        logic [RW-1:0]    rem;
        logic [QBITS-1:0] word;
        logic             neg;
        logic             ovf;
    } lane_t;

    typedef struct packed {
        lane_t [2:0]   lane;
        logic [NW-1:0] n;
        logic          nz;
    } div_item_t;

endpackage

>>> rtl/core/qvr_coef.sv
module qvr_coef
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  qvr_pkg::in_item_t     in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output qvr_pkg::coef_item_t   out_item
);

    localparam int N = 2;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_next;
    logic [N:0]   adv;

    logic signed [qvr_pkg::PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [qvr_pkg::PW-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic [2:0][qvr_pkg::VW-1:0]   v1_reg;
    qvr_pkg::coef_item_t           item_reg;
    qvr_pkg::coef_item_t           item_next;

    always_comb
    begin
        adv[N] = out_ready;
        for (int i = N - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        for (int i = 0; i < N; i++)
        begin
            if (adv[i])
            begin
                vld_next[i] = (i == 0) ? in_valid : vld_reg[i-1];
            end
            else
            begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ww_reg <= $signed(in_item.w) * $signed(in_item.w);
            xx_reg <= $signed(in_item.x) * $signed(in_item.x);
            yy_reg <= $signed(in_item.y) * $signed(in_item.y);
            zz_reg <= $signed(in_item.z) * $signed(in_item.z);
            xy_reg <= $signed(in_item.x) * $signed(in_item.y);
            xz_reg <= $signed(in_item.x) * $signed(in_item.z);
            yz_reg <= $signed(in_item.y) * $signed(in_item.z);
            wx_reg <= $signed(in_item.w) * $signed(in_item.x);
            wy_reg <= $signed(in_item.w) * $signed(in_item.y);
            wz_reg <= $signed(in_item.w) * $signed(in_item.z);
            v1_reg <= {in_item.vz, in_item.vy, in_item.vx};
        end
    end

    always_comb
    begin
        item_next.v = v1_reg;
        item_next.n = {1'b0, ww_reg} + {1'b0, xx_reg} + {1'b0, yy_reg} + {1'b0, zz_reg};
        item_next.c[0] = qvr_pkg::coef_t'(ww_reg) + qvr_pkg::coef_t'(xx_reg)
                       - qvr_pkg::coef_t'(yy_reg) - qvr_pkg::coef_t'(zz_reg);
        item_next.c[1] = (qvr_pkg::coef_t'(xy_reg) - qvr_pkg::coef_t'(wz_reg)) <<< 1;
        item_next.c[2] = (qvr_pkg::coef_t'(xz_reg) + qvr_pkg::coef_t'(wy_reg)) <<< 1;
        item_next.c[3] = (qvr_pkg::coef_t'(xy_reg) + qvr_pkg::coef_t'(wz_reg)) <<< 1;
        item_next.c[4] = qvr_pkg::coef_t'(ww_reg) - qvr_pkg::coef_t'(xx_reg)
                       + qvr_pkg::coef_t'(yy_reg) - qvr_pkg::coef_t'(zz_reg);
        item_next.c[5] = (qvr_pkg::coef_t'(yz_reg) - qvr_pkg::coef_t'(wx_reg)) <<< 1;
        item_next.c[6] = (qvr_pkg::coef_t'(xz_reg) - qvr_pkg::coef_t'(wy_reg)) <<< 1;
        item_next.c[7] = (qvr_pkg::coef_t'(yz_reg) + qvr_pkg::coef_t'(wx_reg)) <<< 1;
        item_next.c[8] = qvr_pkg::coef_t'(ww_reg) - qvr_pkg::coef_t'(xx_reg)
                       - qvr_pkg::coef_t'(yy_reg) + qvr_pkg::coef_t'(zz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            item_reg <= item_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[N-1];
    assign out_item  = item_reg;

endmodule

>>> rtl/core/qvr_mac.sv
module qvr_mac
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  qvr_pkg::coef_item_t   in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output qvr_pkg::div_item_t    out_item
);

    localparam int N = 4;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_next;
    logic [N:0]   adv;

    logic signed [qvr_pkg::MW-1:0] prod_reg [9];
    logic [qvr_pkg::NW-1:0]        n1_reg, n2_reg, n3_reg;
    logic signed [qvr_pkg::SW-1:0] sum_reg [3];
    logic [qvr_pkg::SW-1:0]        mag_reg [3];
    logic [2:0]                    neg_reg;
    qvr_pkg::div_item_t            item_reg;
    qvr_pkg::div_item_t            item_next;

    always_comb
    begin
        adv[N] = out_ready;
        for (int i = N - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        for (int i = 0; i < N; i++)
        begin
            if (adv[i])
            begin
                vld_next[i] = (i == 0) ? in_valid : vld_reg[i-1];
            end
            else
            begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int k = 0; k < 9; k++)
            begin
                prod_reg[k] <= $signed(in_item.c[k]) * $signed(in_item.v[k % 3]);
            end
            n1_reg <= in_item.n;
        end
        if (adv[1])
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= qvr_pkg::SW'(prod_reg[3*r]) + qvr_pkg::SW'(prod_reg[3*r+1])
                            + qvr_pkg::SW'(prod_reg[3*r+2]);
            end
            n2_reg <= n1_reg;
        end
        if (adv[2])
        begin
            for (int r = 0; r < 3; r++)
            begin
                neg_reg[r] <= sum_reg[r][qvr_pkg::SW-1];
                mag_reg[r] <= sum_reg[r][qvr_pkg::SW-1] ? -sum_reg[r] : sum_reg[r];
            end
            n3_reg <= n2_reg;
        end
        if (adv[3])
        begin
            item_reg <= item_next;
        end
    end

    // quotient >= 2^32 exactly when the high part reaches the divisor
    always_comb
    begin
        item_next.n  = n3_reg;
        item_next.nz = (n3_reg != '0);
        for (int r = 0; r < 3; r++)
        begin
            item_next.lane[r].neg  = neg_reg[r];
            item_next.lane[r].ovf  = mag_reg[r][qvr_pkg::SW-1:qvr_pkg::QBITS]
                                   >= (qvr_pkg::SW - qvr_pkg::QBITS)'(n3_reg);
            item_next.lane[r].rem  = mag_reg[r][qvr_pkg::QBITS+qvr_pkg::RW-1:qvr_pkg::QBITS];
            item_next.lane[r].word = mag_reg[r][qvr_pkg::QBITS-1:0];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[N-1];
    assign out_item  = item_reg;

endmodule

>>> rtl/core/qvr_div.sv
module qvr_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  qvr_pkg::div_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output qvr_pkg::div_item_t    out_item
);

    localparam int N = qvr_pkg::DIV_STAGES;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_next;
    logic [N:0]   adv;

    qvr_pkg::div_item_t st_reg  [N];
    qvr_pkg::div_item_t st_next [N];

    always_comb
    begin
        adv[N] = out_ready;
        for (int i = N - 1; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        for (int i = 0; i < N; i++)
        begin
            if (adv[i])
            begin
                vld_next[i] = (i == 0) ? in_valid : vld_reg[i-1];
            end
            else
            begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // one restoring step per stage, quotient bits shift into the low end
    always_comb
    begin
        qvr_pkg::div_item_t  src;
        logic [qvr_pkg::RW:0] trial;
        logic [qvr_pkg::RW:0] diff;
        logic                 ge;
        for (int i = 0; i < N; i++)
        begin
            src = (i == 0) ? in_item : st_reg[(i == 0) ? 0 : i - 1];
            st_next[i] = src;
            for (int r = 0; r < 3; r++)
            begin
                trial = {src.lane[r].rem, src.lane[r].word[qvr_pkg::QBITS-1]};
                diff  = trial - {1'b0, src.n};
                ge    = trial >= {1'b0, src.n};
                st_next[i].lane[r].rem  = ge ? diff[qvr_pkg::RW-1:0] : trial[qvr_pkg::RW-1:0];
                st_next[i].lane[r].word = {src.lane[r].word[qvr_pkg::QBITS-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N; i++)
        begin
            if (adv[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[N-1];
    assign out_item  = st_reg[N-1];

    a_rem_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_item.nz |->
            (in_item.lane[0].ovf || in_item.lane[0].rem < in_item.n) &&
            (in_item.lane[1].ovf || in_item.lane[1].rem < in_item.n) &&
            (in_item.lane[2].ovf || in_item.lane[2].rem < in_item.n))
        else $error("divider entry remainder not below divisor");

    a_rem_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.nz |->
            (out_item.lane[0].ovf || out_item.lane[0].rem < out_item.n) &&
            (out_item.lane[1].ovf || out_item.lane[1].rem < out_item.n) &&
            (out_item.lane[2].ovf || out_item.lane[2].rem < out_item.n))
        else $error("divider final remainder not below divisor");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled divider result lost or changed");

endmodule

>>> rtl/core/quaternion_vector_rotate.sv
// Stages from input transfer to result valid: 2 coefficient, 4 multiply-accumulate,
//   32 restoring divider stages, 1 output register. Throughput: one item per cycle
//   unless m_tready stalls the output; the divider is fully pipelined.
// Backpressure stalls only the stages that hold data; bubbles are filled.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset.
module quaternion_vector_rotate
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z
    input  logic [qvr_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // out_x, out_y, out_z
    output logic [qvr_pkg::OUT_W-1:0]  m_tdata,
    // saturated
    output logic [0:0]                 m_tuser
);

    qvr_pkg::in_item_t   in_item;
    qvr_pkg::coef_item_t coef_item;
    qvr_pkg::div_item_t  mac_item;
    qvr_pkg::div_item_t  div_item;
    logic coef_valid, coef_ready;
    logic mac_valid, mac_ready;
    logic div_valid, div_ready;

    logic                             vld_reg;
    logic [qvr_pkg::OUT_W-1:0]        data_reg;
    logic [qvr_pkg::OUT_W-1:0]        data_next;
    logic                             sat_reg;
    logic                             sat_next;

    assign in_item = qvr_pkg::in_item_t'(s_tdata);

    qvr_coef u_coef
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (coef_valid),
        .out_ready (coef_ready),
        .out_item  (coef_item)
    );

    qvr_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (coef_valid),
        .in_ready  (coef_ready),
        .in_item   (coef_item),
        .out_valid (mac_valid),
        .out_ready (mac_ready),
        .out_item  (mac_item)
    );

    qvr_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mac_valid),
        .in_ready  (mac_ready),
        .in_item   (mac_item),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_item  (div_item)
    );

    // sign restore and clamp; zero norm gives zero
    always_comb
    begin
        logic [qvr_pkg::QBITS-1:0] q;
        logic                      clamp;
        sat_next = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            q = div_item.lane[r].word;
            if (div_item.lane[r].neg)
            begin
                clamp = div_item.lane[r].ovf || (q[qvr_pkg::QBITS-1] && (q[qvr_pkg::QBITS-2:0] != '0));
                data_next[r*qvr_pkg::VW +: qvr_pkg::VW] = clamp ? {1'b1, {(qvr_pkg::VW-1){1'b0}}} : -q;
            end
            else
            begin
                clamp = div_item.lane[r].ovf || q[qvr_pkg::QBITS-1];
                data_next[r*qvr_pkg::VW +: qvr_pkg::VW] = clamp ? {1'b0, {(qvr_pkg::VW-1){1'b1}}} : q;
            end
            if (!div_item.nz)
            begin
                clamp = 1'b0;
                data_next[r*qvr_pkg::VW +: qvr_pkg::VW] = '0;
            end
            sat_next = sat_next | clamp;
        end
    end

    assign div_ready = !vld_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (div_ready)
        begin
            vld_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_ready)
        begin
            data_reg <= data_next;
            sat_reg  <= sat_next;
        end
    end

    assign m_tvalid   = vld_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = sat_reg;

endmodule

>>> tb/sv/tb_quaternion_vector_rotate.sv
module tb_quaternion_vector_rotate;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                      sat;
        logic [qvr_pkg::OUT_W-1:0] vec;
    } rot_result_t;

    class rotation_scoreboard;
        rot_result_t expected_q[$];
        int          mismatches;

        static function logic [31:0] rotate_row(longint c0, longint c1, longint c2,
                                                longint v0, longint v1, longint v2,
                                                longint nrm, ref logic sat);
            logic signed [127:0] acc;
            logic signed [127:0] quo;
            acc = 128'(c0) * 128'(v0) + 128'(c1) * 128'(v1) + 128'(c2) * 128'(v2);
            quo = acc / 128'(nrm);
            if (quo > 128'sd2147483647)
            begin
                sat = 1'b1;
                return 32'h7fff_ffff;
            end
            if (quo < -128'sd2147483648)
            begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return quo[31:0];
        endfunction

        function void note_input(qvr_pkg::in_item_t it);
            longint      x, y, z, w, vx, vy, vz, nrm;
            rot_result_t r;
            logic        sat;
            x = longint'($signed(it.x));
            y = longint'($signed(it.y));
            z = longint'($signed(it.z));
            w = longint'($signed(it.w));
            vx = longint'($signed(it.vx));
            vy = longint'($signed(it.vy));
            vz = longint'($signed(it.vz));
            nrm = w*w + x*x + y*y + z*z;
            sat = 1'b0;
            r = '0;
            if (nrm != 0)
            begin
                r.vec[31:0] = rotate_row(w*w + x*x - y*y - z*z, 2*(x*y - w*z),
                                         2*(x*z + w*y), vx, vy, vz, nrm, sat);
                r.vec[63:32] = rotate_row(2*(x*y + w*z), w*w - x*x + y*y - z*z,
                                          2*(y*z - w*x), vx, vy, vz, nrm, sat);
                r.vec[95:64] = rotate_row(2*(x*z - w*y), 2*(y*z + w*x),
                                          w*w - x*x - y*y + z*z, vx, vy, vz, nrm, sat);
                r.sat = sat;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [qvr_pkg::OUT_W-1:0] data, logic sat);
            rot_result_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h sat %b", data, sat);
                return;
            end
            e = expected_q.pop_front();
            if (e.vec !== data || e.sat !== sat)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %h/%h/%h sat %b, got %h/%h/%h sat %b",
                             e.vec[95:64], e.vec[63:32], e.vec[31:0], e.sat,
                             data[95:64], data[63:32], data[31:0], sat);
            end
        endfunction
    endclass

    localparam int LATENCY    = 39;
    localparam int IDLE_LIMIT = 20000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [qvr_pkg::IN_W-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [qvr_pkg::OUT_W-1:0] m_tdata;
    logic [0:0]                m_tuser;

    rotation_scoreboard rot_sb = new();
    int                 idle_cycles = 0;
    int                 stall_mode = 0;

    quaternion_vector_rotate dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [15:0] pick_quat();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 32768)) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_vec();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(qvr_pkg::in_item_t it);
        int gap;
        gap = (stall_mode == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= it;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        rot_sb.note_input(it);
    endtask

    task automatic send_quat(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                             logic [15:0] w, logic [31:0] vx, logic [31:0] vy,
                             logic [31:0] vz);
        qvr_pkg::in_item_t it;
        it.x = x; it.y = y; it.z = z; it.w = w;
        it.vx = vx; it.vy = vy; it.vz = vz;
        send_item(it);
    endtask

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            rot_sb.check_result(m_tdata, m_tuser[0]);
    end

    initial
    begin
        int wait_left;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready || stall_mode == 0)
            begin
                wait_left = (stall_mode == 0) ? 0 : $urandom_range(0, 19);
                m_tready <= (wait_left == 0);
                while (wait_left > 0)
                begin
                    @(posedge clk);
                    wait_left--;
                    if (wait_left == 0)
                        m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        qvr_pkg::in_item_t it;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_quat(16'h2d41, 16'h0000, 16'h0000, 16'h2d41, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_quat(16'h0000, 16'h2d41, 16'h0000, 16'h2d41, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_quat(16'h0000, 16'h0000, 16'h2d41, 16'hd2bf, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_quat(16'h8000, 16'h7fff, 16'h0000, 16'h0001, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_quat(16'h0001, 16'h0001, 16'h0000, 16'h0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
        send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000, 32'hffff_ffff, 32'h1, 32'hffff_ffff);
        send_quat(16'h0000, 16'h0000, 16'h0001, 16'h0001, 32'h8000_0000, 32'h7fff_ffff, 32'h5);
        send_quat(16'hffff, 16'h0003, 16'hfffe, 16'h0002, 32'h0000_0007, 32'hffff_fff9, 32'h0000_000b);

        s_tvalid <= 1'b0;
        wait (rot_sb.expected_q.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);

        for (int i = 0; i < 500; i++)
        begin
            if (i % 100 == 0)
                stall_mode = $urandom_range(0, 2);
            if (i == 250)
            begin
                s_tvalid <= 1'b0;
                wait (rot_sb.expected_q.size() == 0);
            end
            it.x = pick_quat();
            it.y = pick_quat();
            it.z = pick_quat();
            it.w = pick_quat();
            it.vx = pick_vec();
            it.vy = pick_vec();
            it.vz = pick_vec();
            send_item(it);
        end
        s_tvalid <= 1'b0;
        stall_mode = 0;
        wait (rot_sb.expected_q.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (rot_sb.mismatches == 0 && rot_sb.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
